[rtl/core/mstq_pkg.sv]
// Package for the multi-slot timer queue: operation and status codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package mstq_pkg;

	localparam int unsigned NumSlotsDefault = 8;

	localparam int unsigned OpW      = 3;
	localparam int unsigned TicksW   = 8;
	localparam int unsigned HandlerW = 8;
	localparam int unsigned CtxW     = 8;
	localparam int unsigned DataW    = 32;
	localparam int unsigned SlotW    = 3;
	localparam int unsigned StatusW  = 2;

	// input beat: operation, ticks, periodic, handler, context_req, user_data,
	// has_data, slot, stop = 3+8+1+8+8+32+1+3+1 = 65 bits, padded to 72
	localparam int unsigned InBits  = 65;
	localparam int unsigned InTdW   = 72;
	// output beat: status, slot_out, handler_out, context_out, data_out = 53 bits
	localparam int unsigned OutBits = 53;
	localparam int unsigned OutTdW  = 56;

	typedef enum logic [OpW-1:0] {
		OP_SET    = 3'd0,
		OP_FORK   = 3'd1,
		OP_TICK   = 3'd2,
		OP_TAKE   = 3'd3,
		OP_FINISH = 3'd4
	} op_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_NONE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic exec;      // run single-step op
		logic walk_init; // start tick walk
		logic walk_step; // process one active entry
		logic out_load;  // drive result register
	} mstq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
		logic walk_done;
	} mstq_sts_t;

endpackage

[rtl/core/mstq_ctrl.sv]
// Controller for the timer queue: sequences capture, execution, tick walk and
// result handoff. Depends on mstq_pkg.
module mstq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_free,
	input  mstq_pkg::mstq_sts_t sts,
	output logic                busy,
	output mstq_pkg::mstq_cmd_t cmd
);
	mstq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mstq_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mstq_pkg::S_IDLE: if (in_fire) state_d = mstq_pkg::S_EXEC;
			mstq_pkg::S_EXEC: begin
				if (sts.is_tick) state_d = mstq_pkg::S_WALK;
				else             state_d = mstq_pkg::S_OUT;
			end
			mstq_pkg::S_WALK: if (sts.walk_done) state_d = mstq_pkg::S_OUT;
			mstq_pkg::S_OUT:  if (out_free) state_d = mstq_pkg::S_IDLE;
			default:          state_d = mstq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			mstq_pkg::S_IDLE: begin
				// result registers are rewritten by the next op, so hold off
				// until the pending result beat leaves
				busy     = ~out_free;
				cmd.load = in_fire;
			end
			mstq_pkg::S_EXEC: begin
				cmd.exec      = ~sts.is_tick;
				cmd.walk_init = sts.is_tick;
			end
			mstq_pkg::S_WALK: cmd.walk_step = ~sts.walk_done;
			mstq_pkg::S_OUT:  cmd.out_load  = out_free;
			default: ;
		endcase
	end
endmodule

[rtl/core/mstq_dp.sv]
// Datapath for the timer queue: entry stores, link array, list heads and
// the result register. Depends on mstq_pkg.
module mstq_dp #(
	parameter int unsigned NUM_SLOTS = mstq_pkg::NumSlotsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mstq_pkg::mstq_cmd_t         cmd,
	input  logic [mstq_pkg::InBits-1:0] in_beat,
	output mstq_pkg::mstq_sts_t         sts,
	output logic [mstq_pkg::OutBits-1:0] out_beat,
	output logic                        out_valid,
	input  logic                        out_ready
);
	localparam int unsigned IdxW = $clog2(NUM_SLOTS + 1);
	localparam logic [IdxW-1:0] NoneIdx = IdxW'(NUM_SLOTS);
	localparam int unsigned AW = $clog2(NUM_SLOTS);

	// captured input fields
	logic [mstq_pkg::OpW-1:0]      op_q;
	logic [mstq_pkg::TicksW-1:0]   ticks_q;
	logic                          periodic_q;
	logic [mstq_pkg::HandlerW-1:0] handler_q;
	logic [mstq_pkg::CtxW-1:0]     ctx_q;
	logic [mstq_pkg::DataW-1:0]    udata_q;
	logic                          has_data_q;
	logic [mstq_pkg::SlotW-1:0]    slot_q;
	logic                          stop_q;

	logic [mstq_pkg::TicksW-1:0]   count_q   [NUM_SLOTS];
	logic [mstq_pkg::TicksW-1:0]   reload_q  [NUM_SLOTS];
	logic [mstq_pkg::HandlerW-1:0] hstore_q  [NUM_SLOTS];
	logic [mstq_pkg::CtxW-1:0]     cstore_q  [NUM_SLOTS];
	logic [mstq_pkg::DataW-1:0]    dstore_q  [NUM_SLOTS];
	logic [IdxW-1:0]               link_q    [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]          held_q;
	logic [IdxW-1:0] free_q, active_q, done_q, fork_q;

	// tick walk
	logic [IdxW-1:0] cur_q, prev_q;
	logic [IdxW:0]   nwalk_q;

	logic [mstq_pkg::StatusW-1:0] res_status_q;
	logic [mstq_pkg::SlotW-1:0]   res_slot_q;
	logic [mstq_pkg::HandlerW-1:0] res_h_q;
	logic [mstq_pkg::CtxW-1:0]    res_c_q;
	logic [mstq_pkg::DataW-1:0]   res_d_q;
	logic                         ov_q;

	logic cur_ok, prev_ok, walk_done;
	logic [AW-1:0] cur_a, prev_a;
	assign cur_ok  = cur_q < NoneIdx;
	assign prev_ok = prev_q < NoneIdx;
	assign cur_a   = cur_q[AW-1:0];
	assign prev_a  = prev_q[AW-1:0];
	assign walk_done = !cur_ok || (nwalk_q >= (IdxW+1)'(NUM_SLOTS));

	assign sts.is_tick   = (op_q == mstq_pkg::OP_TICK);
	assign sts.walk_done = walk_done;

	// single-step op decode
	logic free_ok, fork_ok, done_ok, fin_ok;
	logic [AW-1:0] free_a, fork_a, done_a, fin_a;
	assign free_ok = free_q < NoneIdx;
	assign fork_ok = fork_q < NoneIdx;
	assign done_ok = done_q < NoneIdx;
	assign free_a  = free_q[AW-1:0];
	assign fork_a  = fork_q[AW-1:0];
	assign done_a  = done_q[AW-1:0];
	assign fin_a   = AW'(slot_q);
	assign fin_ok  = ({1'b0, slot_q} < (mstq_pkg::SlotW+1)'(NUM_SLOTS)) && held_q[fin_a];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			{stop_q, slot_q, has_data_q, udata_q, ctx_q, handler_q, periodic_q,
			 ticks_q, op_q} <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (op_q == mstq_pkg::OP_SET || op_q == mstq_pkg::OP_FORK)
		    && free_ok) begin
			hstore_q[free_a] <= handler_q;
			cstore_q[free_a] <= ctx_q;
			if (op_q == mstq_pkg::OP_SET) begin
				count_q[free_a]  <= ticks_q;
				reload_q[free_a] <= periodic_q ? ticks_q : '0;
			end else begin
				reload_q[free_a] <= '0;
			end
		end else if (cmd.exec && op_q == mstq_pkg::OP_FINISH && fin_ok && !stop_q
		             && reload_q[fin_a] != '0) begin
			count_q[fin_a] <= reload_q[fin_a];
		end else if (cmd.walk_step && count_q[cur_a] != '0) begin
			count_q[cur_a] <= count_q[cur_a] - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				dstore_q[i] <= '0;
				link_q[i]   <= IdxW'(i + 1);
			end
			held_q   <= '0;
			free_q   <= '0;
			active_q <= NoneIdx;
			done_q   <= NoneIdx;
			fork_q   <= NoneIdx;
			cur_q    <= NoneIdx;
			prev_q   <= NoneIdx;
			nwalk_q  <= '0;
			res_status_q <= '0;
			res_slot_q   <= '0;
			res_h_q      <= '0;
			res_c_q      <= '0;
			res_d_q      <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (cmd.exec) begin
				res_status_q <= mstq_pkg::ST_OK;
				res_slot_q   <= '0;
				res_h_q      <= '0;
				res_c_q      <= '0;
				res_d_q      <= '0;
				priority case (op_q)
					mstq_pkg::OP_SET, mstq_pkg::OP_FORK: begin
						if (!free_ok) begin
							res_status_q <= mstq_pkg::ST_NO_FREE;
						end else begin
							free_q <= link_q[free_a];
							if (has_data_q) dstore_q[free_a] <= udata_q;
							res_slot_q <= mstq_pkg::SlotW'(free_a);
							if (op_q == mstq_pkg::OP_FORK) begin
								link_q[free_a] <= fork_q;
								fork_q <= free_q;
							end else if (ticks_q != '0) begin
								link_q[free_a] <= active_q;
								active_q <= free_q;
							end else begin
								link_q[free_a] <= done_q;
								done_q <= free_q;
							end
						end
					end
					mstq_pkg::OP_TAKE: begin
						if (fork_ok) begin
							fork_q <= link_q[fork_a];
							held_q[fork_a] <= 1'b1;
							res_slot_q <= mstq_pkg::SlotW'(fork_a);
							res_h_q <= hstore_q[fork_a];
							res_c_q <= cstore_q[fork_a];
							res_d_q <= dstore_q[fork_a];
						end else if (done_ok) begin
							done_q <= link_q[done_a];
							held_q[done_a] <= 1'b1;
							res_slot_q <= mstq_pkg::SlotW'(done_a);
							res_h_q <= hstore_q[done_a];
							res_c_q <= cstore_q[done_a];
							res_d_q <= dstore_q[done_a];
						end else begin
							res_status_q <= mstq_pkg::ST_NONE;
						end
					end
					mstq_pkg::OP_FINISH: begin
						if (fin_ok) begin
							held_q[fin_a] <= 1'b0;
							if (!stop_q && reload_q[fin_a] != '0) begin
								link_q[fin_a] <= active_q;
								active_q <= IdxW'(fin_a);
							end else begin
								link_q[fin_a] <= free_q;
								free_q <= IdxW'(fin_a);
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.walk_init) begin
				res_status_q <= mstq_pkg::ST_OK;
				res_slot_q   <= '0;
				res_h_q      <= '0;
				res_c_q      <= '0;
				res_d_q      <= '0;
				cur_q   <= active_q;
				prev_q  <= NoneIdx;
				nwalk_q <= '0;
			end
			if (cmd.walk_step) begin
				nwalk_q <= nwalk_q + 1'b1;
				cur_q   <= link_q[cur_a];
				if (count_q[cur_a] != '0) begin
					prev_q <= cur_q;
				end else begin
					if (prev_ok) link_q[prev_a] <= link_q[cur_a];
					else         active_q <= link_q[cur_a];
					link_q[cur_a] <= done_q;
					done_q <= cur_q;
				end
			end
			if (cmd.out_load)                ov_q <= 1'b1;
			else if (out_valid && out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign out_beat  = {res_d_q, res_c_q, res_h_q, res_slot_q, res_status_q};
endmodule

[rtl/core/multi_slot_timer_queue.sv]
// Multi-slot timer queue: entry pool on free/active/done/fork linked lists.
// Each beat passes capture, execute and result states; a tick also walks the
// active list between execute and result, one entry per cycle, at most NUM_SLOTS.
// Throughput: one beat at a time; the next input beat is taken at the edge the
// result leaves the output register or later. Reset (arst_n low) empties all
// lists but free, which holds every entry in index order; user data clears to zero.
module multi_slot_timer_queue #(
	parameter int unsigned NUM_SLOTS = mstq_pkg::NumSlotsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata, low to high: operation[2:0], ticks[10:3], periodic[11],
	// handler[19:12], context_req[27:20], user_data[59:28], has_data[60],
	// slot[63:61], stop[64], zero fill
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mstq_pkg::InTdW-1:0]    s_tdata,
	// m_tdata, low to high: status[1:0], slot_out[4:2], handler_out[12:5],
	// context_out[20:13], data_out[52:21], zero fill
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mstq_pkg::OutTdW-1:0]   m_tdata
);
	mstq_pkg::mstq_cmd_t cmd;
	mstq_pkg::mstq_sts_t sts;
	logic busy, in_fire, out_free;
	logic [mstq_pkg::OutBits-1:0] out_beat;

	assign s_tready = ~busy;
	assign in_fire  = s_tvalid & s_tready;
	// result register may be refilled once the previous beat has gone
	assign out_free = ~m_tvalid | m_tready;

	mstq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	mstq_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_beat   (s_tdata[mstq_pkg::InBits-1:0]),
		.sts       (sts),
		.out_beat  (out_beat),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = {{(mstq_pkg::OutTdW - mstq_pkg::OutBits){1'b0}}, out_beat};
endmodule

[verif/multi_slot_timer_queue_tb.sv]
// Testbench for multi_slot_timer_queue: directed and random operation beats,
// checked against an in-bench predictor of the entry lists.
// Depends on mstq_pkg and the multi_slot_timer_queue RTL.
`timescale 1ns / 100ps

module multi_slot_timer_queue_tb;

	localparam int unsigned NS = 8;
	localparam logic [3:0] NIL = 4'd8;
	localparam longint CycleLimit = 2000000;

	// field order matches m_tdata: status in the low bits
	typedef struct packed {
		logic [31:0] data_out;
		logic [7:0]  context_out;
		logic [7:0]  handler_out;
		logic [2:0]  slot_out;
		logic [1:0]  status;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mstq_pkg::InTdW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mstq_pkg::OutTdW-1:0] m_tdata;

	multi_slot_timer_queue dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: mirror of the entry pool and its four lists
	logic [7:0]  cnt_q [NS];
	logic [7:0]  reload_q [NS];
	logic [7:0]  hdl_q [NS];
	logic [7:0]  ctx_q [NS];
	logic [31:0] data_q [NS];
	logic [3:0]  link_q [NS];
	bit          held_q [NS];
	logic [3:0]  free_hd, act_hd, done_hd, fork_hd;

	timer_result_t expected_results[$];
	int  errors = 0;
	bit  idle_on = 1'b1;
	longint cycles = 0;

	// advance the predictor by one operation beat and queue its result
	function automatic void predict_op(input logic [mstq_pkg::InTdW-1:0] d);
		timer_result_t r;
		logic [2:0] op;
		logic [7:0] tk;
		logic [3:0] e, prv, cur, nxt;
		logic [2:0] sl;
		r = '0;
		op = d[2:0];
		tk = d[10:3];
		if (op == mstq_pkg::OP_SET || op == mstq_pkg::OP_FORK) begin
			e = free_hd;
			if (e == NIL) r.status = mstq_pkg::ST_NO_FREE;
			else begin
				free_hd = link_q[e];
				hdl_q[e] = d[19:12];
				ctx_q[e] = d[27:20];
				if (d[60]) data_q[e] = d[59:28];
				if (op == mstq_pkg::OP_SET) begin
					cnt_q[e] = tk;
					reload_q[e] = d[11] ? tk : 8'd0;
					if (tk != 0) begin link_q[e] = act_hd; act_hd = e; end
					else begin link_q[e] = done_hd; done_hd = e; end
				end else begin
					reload_q[e] = 8'd0;
					link_q[e] = fork_hd;
					fork_hd = e;
				end
				r.slot_out = e[2:0];
			end
		end else if (op == mstq_pkg::OP_TICK) begin
			prv = NIL;
			cur = act_hd;
			for (int n = 0; n < NS && cur != NIL; n++) begin
				nxt = link_q[cur];
				if (cnt_q[cur] != 0) begin
					cnt_q[cur] = cnt_q[cur] - 8'd1;
					prv = cur;
				end else begin
					if (prv != NIL) link_q[prv] = nxt;
					else act_hd = nxt;
					link_q[cur] = done_hd;
					done_hd = cur;
				end
				cur = nxt;
			end
		end else if (op == mstq_pkg::OP_TAKE) begin
			e = fork_hd;
			if (e != NIL) fork_hd = link_q[e];
			else begin
				e = done_hd;
				if (e != NIL) done_hd = link_q[e];
			end
			if (e == NIL) r.status = mstq_pkg::ST_NONE;
			else begin
				held_q[e] = 1'b1;
				r.slot_out = e[2:0];
				r.handler_out = hdl_q[e];
				r.context_out = ctx_q[e];
				r.data_out = data_q[e];
			end
		end else if (op == mstq_pkg::OP_FINISH) begin
			sl = d[63:61];
			if (held_q[sl]) begin
				held_q[sl] = 1'b0;
				if (!d[64] && reload_q[sl] != 0) begin
					cnt_q[sl] = reload_q[sl];
					link_q[sl] = act_hd;
					act_hd = {1'b0, sl};
				end else begin
					link_q[sl] = free_hd;
					free_hd = {1'b0, sl};
				end
			end
		end
		expected_results.push_back(r);
	endfunction

	function automatic logic [mstq_pkg::InTdW-1:0] pack_op(input logic [2:0] op,
			input logic [7:0] tk, input bit per, input logic [7:0] hdl, input logic [7:0] ctx,
			input logic [31:0] ud, input bit hd, input logic [2:0] sl, input bit stp);
		return {7'd0, stp, sl, hd, ud, ctx, hdl, per, tk, op};
	endfunction

	// send one beat, with an optional idle burst first; valid stays up between
	// back-to-back beats and is dropped by an idle burst or a drain
	task automatic send_op(input logic [mstq_pkg::InTdW-1:0] d);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		predict_op(d);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_rand(input logic [2:0] op);
		send_op(pack_op(op, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
			1'($urandom), 8'($urandom), 8'($urandom), $urandom, 1'($urandom),
			3'($urandom), ($urandom_range(0, 3) == 0)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall bursts, compare each result beat
	initial begin
		timer_result_t got, want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata[mstq_pkg::OutBits-1:0];
				if (expected_results.size() == 0) begin
					$error("unexpected result beat %h", got);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, got.status); errors++; end
					if (got.slot_out !== want.slot_out) begin
						$error("slot_out exp %0d got %0d", want.slot_out, got.slot_out); errors++; end
					if (got.handler_out !== want.handler_out) begin
						$error("handler_out exp %h got %h", want.handler_out, got.handler_out);
						errors++; end
					if (got.context_out !== want.context_out) begin
						$error("context_out exp %h got %h", want.context_out, got.context_out);
						errors++; end
					if (got.data_out !== want.data_out) begin
						$error("data_out exp %h got %h", want.data_out, got.data_out); errors++; end
				end
			end
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("multi_slot_timer_queue: mismatch");
				$finish;
			end
		end
	end

	// extremes, every operation, pool exhaustion, empty take, stray finishes
	task automatic test_directed();
		send_op(pack_op(mstq_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_op(pack_op(mstq_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0, 3'd7, 0));
		send_op(pack_op(mstq_pkg::OP_SET, 8'd0, 1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 3'd7, 1));
		send_op(pack_op(mstq_pkg::OP_SET, 8'd1, 1, 8'h00, 8'h00, 32'h0, 0, 0, 0));
		send_op(pack_op(mstq_pkg::OP_SET, 8'd255, 0, 8'hA5, 8'h5A, 32'h1234_5678, 1, 0, 0));
		send_op(pack_op(mstq_pkg::OP_FORK, 8'd9, 1, 8'h3C, 8'hC3, 32'hDEAD_BEEF, 1, 0, 0));
		for (int i = 0; i < 5; i++) send_rand(mstq_pkg::OP_SET);
		send_op(pack_op(mstq_pkg::OP_FORK, 0, 0, 1, 2, 3, 1, 0, 0));
		send_op(pack_op(mstq_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0, 3'd2, 0));
		send_op(pack_op(mstq_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		send_op(pack_op(mstq_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		send_op(pack_op(3'd5, 8'hFF, 1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 3'd7, 1));
		send_op(pack_op(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 4; i++)
			send_op(pack_op(mstq_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_op(pack_op(mstq_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0, 3'd1, 0));
		send_op(pack_op(mstq_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0, 3'd0, 1));
		wait_drained();
	endtask

	// mostly coherent traffic: take then finish of a held entry, plus noise
	task automatic test_random(input int n);
		int k;
		logic [2:0] pick;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 25) send_rand(mstq_pkg::OP_SET);
			else if (k < 33) send_rand(mstq_pkg::OP_FORK);
			else if (k < 55) send_rand(mstq_pkg::OP_TICK);
			else if (k < 72) send_rand(mstq_pkg::OP_TAKE);
			else if (k < 95) begin
				pick = 3'($urandom);
				for (int s = 0; s < NS; s++)
					if (held_q[(pick + s) % NS]) begin pick = 3'((pick + s) % NS); break; end
				send_op(pack_op(mstq_pkg::OP_FINISH, 8'($urandom), 1'($urandom), 8'($urandom),
					8'($urandom), $urandom, 1'($urandom), pick, ($urandom_range(0, 3) == 0)));
			end else send_rand(3'($urandom_range(4, 7)));
			if (i == n / 2) wait_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < NS; i++) begin
			cnt_q[i] = '0; reload_q[i] = '0; hdl_q[i] = '0; ctx_q[i] = '0;
			data_q[i] = '0; link_q[i] = 4'(i + 1); held_q[i] = 1'b0;
		end
		free_hd = 4'd0; act_hd = NIL; done_hd = NIL; fork_hd = NIL;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1100);
		idle_on = 1'b0;
		test_random(300);
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("multi_slot_timer_queue: match");
		else
			$display("multi_slot_timer_queue: mismatch");
		$finish;
	end

endmodule
